// File: rtl/core/pncw_pkg.sv
// Package for the note command writer: item, shadow view and command plan types,
// plus the command byte field codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pncw_pkg;

    localparam int MAX_BYTES = 4;

    localparam logic [1:0] NOISE_VOICE = 2'd3;
    localparam logic [3:0] ATT_OFF     = 4'hF;

    // Command byte prefixes.
    localparam logic       CMD_LATCH   = 1'b1;
    localparam logic       REG_TONE    = 1'b0;
    localparam logic       REG_VOLUME  = 1'b1;
    localparam logic [4:0] NOISE_CMD   = 5'b11100;
    localparam logic [1:0] DATA_PREFIX = 2'b00;

    typedef struct packed {
        logic [1:0] voice;
        logic       is_end;
        logic       silent_note;
        logic [3:0] attenuation;
        logic [9:0] tone_period;
        logic [2:0] noise_mode;
    } t_item;

    // Shadow state of the addressed voice.
    typedef struct packed {
        logic       quiet;
        logic       vol_known;
        logic [3:0] vol_shadow;
        logic       tone_known;
        logic [9:0] tone_shadow;
        logic       noise_known;
        logic [2:0] noise_shadow;
    } t_view;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      sounding;
    } t_plan;

endpackage

`default_nettype wire

// File: rtl/core/pncw_cmd_plan.sv
// Combinational command planner: turns one note event and the shadow state of its
// voice into the ordered list of command bytes. Depends on pncw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pncw_cmd_plan (
    input  wire pncw_pkg::t_item i_item,
    input  wire pncw_pkg::t_view i_view,
    output pncw_pkg::t_plan      o_plan
);

    logic       w_is_noise;
    logic       w_silence;
    logic       w_audible;
    logic       w_differs;
    logic       w_off_write;
    logic       w_att_write;
    logic [7:0] w_off_byte;
    logic [7:0] w_att_byte;
    logic [7:0] w_tone_lo;
    logic [7:0] w_tone_hi;
    logic [7:0] w_noise_byte;
    logic [2:0] w_cnt;
    logic [pncw_pkg::MAX_BYTES-1:0][7:0] w_bytes;

    assign w_is_noise = (i_item.voice == pncw_pkg::NOISE_VOICE);
    assign w_silence  = i_item.is_end || i_item.silent_note ||
                        (i_item.attenuation == pncw_pkg::ATT_OFF) ||
                        (!w_is_noise && (i_item.tone_period == 10'd0));
    assign w_audible  = !i_view.quiet && i_view.vol_known &&
                        (i_view.vol_shadow != pncw_pkg::ATT_OFF);
    assign w_differs  = w_is_noise ?
                        (!i_view.noise_known || (i_view.noise_shadow != i_item.noise_mode)) :
                        (!i_view.tone_known || (i_view.tone_shadow != i_item.tone_period));

    // The off byte serves both a silencing event and the mute before a retune.
    // A mute always leaves the volume shadow at off, so the new level follows.
    assign w_off_write = w_silence ?
                         (!i_view.quiet &&
                          !(i_view.vol_known && (i_view.vol_shadow == pncw_pkg::ATT_OFF))) :
                         (w_audible && w_differs);
    assign w_att_write = !w_silence && (w_off_write || !i_view.vol_known ||
                                        (i_view.vol_shadow != i_item.attenuation));

    assign w_off_byte   = {pncw_pkg::CMD_LATCH, i_item.voice, pncw_pkg::REG_VOLUME,
                           pncw_pkg::ATT_OFF};
    assign w_att_byte   = {pncw_pkg::CMD_LATCH, i_item.voice, pncw_pkg::REG_VOLUME,
                           i_item.attenuation};
    assign w_tone_lo    = {pncw_pkg::CMD_LATCH, i_item.voice, pncw_pkg::REG_TONE,
                           i_item.tone_period[3:0]};
    assign w_tone_hi    = {pncw_pkg::DATA_PREFIX, i_item.tone_period[9:4]};
    assign w_noise_byte = {pncw_pkg::NOISE_CMD, i_item.noise_mode};

    always_comb begin
        w_bytes = '0;
        w_cnt   = 3'd0;
        if (w_off_write) begin
            w_bytes[w_cnt[1:0]] = w_off_byte;
            w_cnt = w_cnt + 3'd1;
        end
        if (!w_silence && w_differs) begin
            if (w_is_noise) begin
                w_bytes[w_cnt[1:0]] = w_noise_byte;
                w_cnt = w_cnt + 3'd1;
            end else begin
                w_bytes[w_cnt[1:0]] = w_tone_lo;
                w_cnt = w_cnt + 3'd1;
                w_bytes[w_cnt[1:0]] = w_tone_hi;
                w_cnt = w_cnt + 3'd1;
            end
        end
        if (w_att_write) begin
            w_bytes[w_cnt[1:0]] = w_att_byte;
            w_cnt = w_cnt + 3'd1;
        end
    end

    assign o_plan.bytes    = w_bytes;
    assign o_plan.count    = w_cnt;
    assign o_plan.sounding = !w_silence;

endmodule

`default_nettype wire

// File: rtl/core/psg_note_command_writer_unit.sv
// Top level of the note command writer: input register, shadow registers and the
// output burst register. Depends on pncw_pkg and pncw_cmd_plan.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted note event becomes a burst of one to four result beats, one beat
// per clock while the consumer is ready. A beat with o_write_valid high carries a
// command byte; an event that needs no byte gives a single beat with
// o_write_valid low and o_chip_byte zero. o_last marks the final beat of an event,
// and o_start_playback is high on that final beat when the event is a sounding
// note. An event enters the input register, is planned against the voice's shadow
// state and loaded into the burst register when that is free or in the cycle the
// previous burst ends, and its first beat is presented from the burst register.
// Throughput is set by the single output port, which carries max(n, 1) beats for
// an event with n command bytes. The input register takes the next event while a
// burst is still draining. Shadow state is updated when an event is planned and
// is cleared only by reset.
module psg_note_command_writer_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [1:0] i_voice,
    input  wire        i_is_end,
    input  wire        i_silent_note,
    input  wire  [3:0] i_attenuation,
    input  wire  [9:0] i_tone_period,
    input  wire  [2:0] i_noise_mode,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_write_valid,
    output logic [7:0] o_chip_byte,
    output logic       o_start_playback,
    output logic       o_last
);

    // Input register.
    logic             r_in_valid;
    pncw_pkg::t_item  r_in;

    // Shadow registers. Values are only read once their known bit is set.
    logic [9:0] r_tone_shadow  [3];
    logic [2:0] r_tone_known;
    logic [3:0] r_vol_shadow   [4];
    logic [3:0] r_vol_known;
    logic [2:0] r_noise_shadow;
    logic       r_noise_known;
    logic [3:0] r_quiet;

    // Output burst register.
    logic                                r_out_valid;
    logic [pncw_pkg::MAX_BYTES-1:0][7:0] r_bytes;
    logic [1:0]                          r_last_idx;
    logic [1:0]                          r_idx;
    logic                                r_wv;
    logic                                r_sounding;

    pncw_pkg::t_view w_view;
    pncw_pkg::t_plan w_plan;
    logic            w_is_noise;
    logic            w_beat;
    logic            w_burst_end;
    logic            w_advance;
    logic [1:0]      n_last_idx;

    assign w_is_noise  = (r_in.voice == pncw_pkg::NOISE_VOICE);
    assign w_beat      = r_out_valid && i_out_ready;
    assign w_burst_end = w_beat && (r_idx == r_last_idx);
    // The queued event is planned when the burst register is free or frees now.
    assign w_advance   = r_in_valid && (!r_out_valid || w_burst_end);
    assign o_in_ready  = !r_in_valid || w_advance;

    // The tone shadow is only looked at for the three tone voices.
    always_comb begin
        w_view.quiet        = r_quiet[r_in.voice];
        w_view.vol_known    = r_vol_known[r_in.voice];
        w_view.vol_shadow   = r_vol_shadow[r_in.voice];
        w_view.noise_known  = r_noise_known;
        w_view.noise_shadow = r_noise_shadow;
        if (w_is_noise) begin
            w_view.tone_known  = 1'b0;
            w_view.tone_shadow = '0;
        end else begin
            w_view.tone_known  = r_tone_known[r_in.voice];
            w_view.tone_shadow = r_tone_shadow[r_in.voice];
        end
    end

    pncw_cmd_plan u_plan (
        .i_item (r_in),
        .i_view (w_view),
        .o_plan (w_plan)
    );

    assign n_last_idx = (w_plan.count == 3'd0) ? 2'd0 : 2'(w_plan.count - 3'd1);

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in.voice       <= i_voice;
            r_in.is_end      <= i_is_end;
            r_in.silent_note <= i_silent_note;
            r_in.attenuation <= i_attenuation;
            r_in.tone_period <= i_tone_period;
            r_in.noise_mode  <= i_noise_mode;
        end
    end

    // Known bits and quiet flags. A silencing event on a sounding voice always
    // leaves the volume at off; a sounding event leaves it at the new level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_known  <= '0;
            r_vol_known   <= '0;
            r_noise_known <= 1'b0;
            r_quiet       <= '1;
        end else if (w_advance) begin
            if (w_plan.sounding) begin
                r_vol_known[r_in.voice] <= 1'b1;
                r_quiet[r_in.voice]     <= 1'b0;
                if (w_is_noise) begin
                    r_noise_known <= 1'b1;
                end else begin
                    r_tone_known[r_in.voice] <= 1'b1;
                end
            end else if (!w_view.quiet) begin
                r_vol_known[r_in.voice] <= 1'b1;
                r_quiet[r_in.voice]     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (w_plan.sounding) begin
                r_vol_shadow[r_in.voice] <= r_in.attenuation;
                if (w_is_noise) begin
                    r_noise_shadow <= r_in.noise_mode;
                end else begin
                    r_tone_shadow[r_in.voice] <= r_in.tone_period;
                end
            end else if (!w_view.quiet) begin
                r_vol_shadow[r_in.voice] <= pncw_pkg::ATT_OFF;
            end
        end
    end

    // Burst register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
            r_idx       <= 2'd0;
        end else if (w_burst_end) begin
            r_out_valid <= 1'b0;
        end else if (w_beat) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_bytes    <= w_plan.bytes;
            r_last_idx <= n_last_idx;
            r_wv       <= (w_plan.count != 3'd0);
            r_sounding <= w_plan.sounding;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_write_valid    = r_wv;
    assign o_chip_byte      = r_bytes[r_idx];
    assign o_last           = (r_idx == r_last_idx);
    assign o_start_playback = r_sounding && (r_idx == r_last_idx);

endmodule

`default_nettype wire

// File: rtl/core/pncw_checker.sv
// Port-level checker for psg_note_command_writer_unit and its bind statement.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module pncw_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire       o_write_valid,
    input wire [7:0] o_chip_byte,
    input wire       o_start_playback,
    input wire       o_last
);

    // A stalled beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_chip_byte) && $stable(o_last) &&
            $stable(o_write_valid) && $stable(o_start_playback))
        else $error("pncw: stalled beat changed");

    // An event with no command byte is a single, empty, final beat.
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_valid |-> o_last && (o_chip_byte == 8'd0))
        else $error("pncw: empty beat not final or not zero");

    // Playback start is only flagged on the final beat of an event.
    a_start_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_start_playback |-> o_last)
        else $error("pncw: start_playback on a non-final beat");

    // A burst continues without a gap once begun.
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid && o_write_valid)
        else $error("pncw: burst broken before its final beat");

endmodule

bind psg_note_command_writer_unit pncw_checker u_pncw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_write_valid    (o_write_valid),
    .o_chip_byte      (o_chip_byte),
    .o_start_playback (o_start_playback),
    .o_last           (o_last)
);

`default_nettype wire

// File: tb/tb_psg_note_command_writer_unit.sv
// Self-checking testbench for psg_note_command_writer_unit: random and directed note
// events, with an in-order predictor of the command bytes. Depends on pncw_pkg.
`timescale 1ns / 1ps

module tb_psg_note_command_writer_unit;

    localparam int RANDOM_EVENTS = 228;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    // One result beat as the block presents it.
    typedef struct packed {
        logic       write_valid;
        logic [7:0] chip_byte;
        logic       start_playback;
        logic       last;
    } t_chip_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_voice;
    logic       i_is_end;
    logic       i_silent_note;
    logic [3:0] i_attenuation;
    logic [9:0] i_tone_period;
    logic [2:0] i_noise_mode;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_write_valid;
    logic [7:0] o_chip_byte;
    logic       o_start_playback;
    logic       o_last;

    // Note events waiting for the driver, and beats the predictor says must come out.
    pncw_pkg::t_item pending_events[$];
    t_chip_beat      expected_beats[$];
    logic [7:0]      cmd_burst[$];

    // Predictor copy of the chip shadow registers. The *_valid bits say whether the
    // chip is known to hold the value; muted mirrors the per-voice quiet flag.
    logic [9:0] tone_reg    [0:2];
    logic       tone_valid  [0:2];
    logic [3:0] atten_reg   [0:3];
    logic       atten_valid [0:3];
    logic [2:0] noise_reg;
    logic       noise_valid;
    logic       muted       [0:3];

    int              mismatch_count;
    int              cycle_count;
    int              stall_count;
    pncw_pkg::t_item next_event;
    pncw_pkg::t_item taken_event;
    logic            calm;

    psg_note_command_writer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_voice          (i_voice),
        .i_is_end         (i_is_end),
        .i_silent_note    (i_silent_note),
        .i_attenuation    (i_attenuation),
        .i_tone_period    (i_tone_period),
        .i_noise_mode     (i_noise_mode),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_valid    (o_write_valid),
        .o_chip_byte      (o_chip_byte),
        .o_start_playback (o_start_playback),
        .o_last           (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Neither side idles inside this window, so the block also sees back-to-back
    // traffic on both ports.
    assign calm = (cycle_count >= 400) && (cycle_count < 900);

    // Writes an attenuation command unless the chip already holds that value.
    task automatic write_atten(input logic [1:0] v, input logic [3:0] att);
        if (!(atten_valid[v] && atten_reg[v] == att)) begin
            cmd_burst.push_back({pncw_pkg::CMD_LATCH, v, pncw_pkg::REG_VOLUME, att});
            atten_reg[v]   = att;
            atten_valid[v] = 1'b1;
        end
    endtask

    // Works out the command bytes one note event causes, updates the shadow copy,
    // and queues the resulting beats.
    task automatic predict_commands(input pncw_pkg::t_item ev);
        logic       sounding;
        logic       audible;
        logic       change;
        logic [1:0] v;
        int         k;
        t_chip_beat beat;
        v = ev.voice;
        cmd_burst.delete();
        if (ev.is_end || ev.silent_note || ev.attenuation == pncw_pkg::ATT_OFF ||
            (v != pncw_pkg::NOISE_VOICE && ev.tone_period == '0)) begin
            // Rests, ends and full attenuation silence a sounding voice once.
            sounding = 1'b0;
            if (!muted[v]) begin
                write_atten(v, pncw_pkg::ATT_OFF);
                muted[v] = 1'b1;
            end
        end else begin
            sounding = 1'b1;
            audible  = !muted[v] && atten_valid[v] && atten_reg[v] != pncw_pkg::ATT_OFF;
            if (v != pncw_pkg::NOISE_VOICE) begin
                change = !tone_valid[v] || tone_reg[v] != ev.tone_period;
                // A voice that can be heard is muted before it is retuned.
                if (audible && change) begin
                    write_atten(v, pncw_pkg::ATT_OFF);
                end
                if (change) begin
                    cmd_burst.push_back({pncw_pkg::CMD_LATCH, v, pncw_pkg::REG_TONE,
                                         ev.tone_period[3:0]});
                    cmd_burst.push_back({pncw_pkg::DATA_PREFIX, ev.tone_period[9:4]});
                    tone_reg[v]   = ev.tone_period;
                    tone_valid[v] = 1'b1;
                end
            end else begin
                change = !noise_valid || noise_reg != ev.noise_mode;
                if (audible && change) begin
                    write_atten(v, pncw_pkg::ATT_OFF);
                end
                if (change) begin
                    cmd_burst.push_back({pncw_pkg::NOISE_CMD, ev.noise_mode});
                    noise_reg   = ev.noise_mode;
                    noise_valid = 1'b1;
                end
            end
            write_atten(v, ev.attenuation);
            muted[v] = 1'b0;
        end
        if (cmd_burst.size() == 0) begin
            // Nothing to write still gives one beat that closes the event.
            beat.write_valid    = 1'b0;
            beat.chip_byte      = '0;
            beat.start_playback = sounding;
            beat.last           = 1'b1;
            expected_beats.push_back(beat);
        end else begin
            for (k = 0; k < cmd_burst.size(); k++) begin
                beat.write_valid    = 1'b1;
                beat.chip_byte      = cmd_burst[k];
                beat.last           = (k == cmd_burst.size() - 1);
                beat.start_playback = beat.last && sounding;
                expected_beats.push_back(beat);
            end
        end
    endtask

    task automatic add_event(input logic [1:0] v, input logic e, input logic s,
                             input logic [3:0] att, input logic [9:0] period,
                             input logic [2:0] mode);
        pncw_pkg::t_item ev;
        ev.voice       = v;
        ev.is_end      = e;
        ev.silent_note = s;
        ev.attenuation = att;
        ev.tone_period = period;
        ev.noise_mode  = mode;
        pending_events.push_back(ev);
    endtask

    // Driver: a new event is presented only when the previous one has been taken
    // or nothing was presented, so valid and the payload hold until the handshake.
    // The predictor runs on the event taken at this edge, in acceptance order.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                taken_event.voice       = i_voice;
                taken_event.is_end      = i_is_end;
                taken_event.silent_note = i_silent_note;
                taken_event.attenuation = i_attenuation;
                taken_event.tone_period = i_tone_period;
                taken_event.noise_mode  = i_noise_mode;
                predict_commands(taken_event);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_events.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
                    next_event = pending_events.pop_front();
                    i_in_valid    <= 1'b1;
                    i_voice       <= next_event.voice;
                    i_is_end      <= next_event.is_end;
                    i_silent_note <= next_event.silent_note;
                    i_attenuation <= next_event.attenuation;
                    i_tone_period <= next_event.tone_period;
                    i_noise_mode  <= next_event.noise_mode;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the output port now and then and checks every beat taken
    // against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 6);
            if (o_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("unexpected beat: write_valid=%0b chip_byte=%02h",
                           o_write_valid, o_chip_byte);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    if (o_write_valid !== expected_beats[0].write_valid) begin
                        $error("write_valid: expected %0b, got %0b",
                               expected_beats[0].write_valid, o_write_valid);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (o_chip_byte !== expected_beats[0].chip_byte) begin
                        $error("chip_byte: expected %02h, got %02h",
                               expected_beats[0].chip_byte, o_chip_byte);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (o_start_playback !== expected_beats[0].start_playback) begin
                        $error("start_playback: expected %0b, got %0b",
                               expected_beats[0].start_playback, o_start_playback);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (o_last !== expected_beats[0].last) begin
                        $error("last: expected %0b, got %0b",
                               expected_beats[0].last, o_last);
                        mismatch_count = mismatch_count + 1;
                    end
                    void'(expected_beats.pop_front());
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no beat on either port means a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        logic [9:0] tone_pool [0:3];
        logic [3:0] att_pool  [0:2];
        logic [1:0] v;
        logic [9:0] period;
        logic [3:0] att;
        logic [2:0] mode;
        int         r;
        int         n;
        int         i;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_voice        = '0;
        i_is_end       = 1'b0;
        i_silent_note  = 1'b0;
        i_attenuation  = '0;
        i_tone_period  = '0;
        i_noise_mode   = '0;
        i_out_ready    = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        stall_count    = 0;

        // The predictor starts from the reset state: nothing known, all voices quiet.
        for (i = 0; i < 4; i++) begin
            atten_reg[i]   = '0;
            atten_valid[i] = 1'b0;
            muted[i]       = 1'b1;
        end
        for (i = 0; i < 3; i++) begin
            tone_reg[i]   = '0;
            tone_valid[i] = 1'b0;
        end
        noise_reg   = '0;
        noise_valid = 1'b0;

        // Directed events. First sound on a fresh voice writes tone and volume, a
        // repeat writes nothing, and a retune of a sounding voice mutes it first.
        add_event(2'd0, 1'b0, 1'b0, 4'd0,  10'd1023, 3'd0);
        add_event(2'd0, 1'b0, 1'b0, 4'd0,  10'd1023, 3'd0);
        add_event(2'd0, 1'b0, 1'b0, 4'd0,  10'd1,    3'd5);
        add_event(2'd0, 1'b0, 1'b0, 4'd14, 10'd1,    3'd0);
        // End of stream silences once; the second end finds the voice quiet.
        add_event(2'd0, 1'b1, 1'b0, 4'd14, 10'd1,    3'd0);
        add_event(2'd0, 1'b1, 1'b0, 4'd14, 10'd1,    3'd0);
        // Restart of a quiet voice on the same tone needs only the volume.
        add_event(2'd0, 1'b0, 1'b0, 4'd14, 10'd1,    3'd0);
        add_event(2'd0, 1'b0, 1'b1, 4'd3,  10'd1,    3'd0);
        // Rests on tone voices, on a quiet and on a sounding voice.
        add_event(2'd1, 1'b0, 1'b0, 4'd3,  10'd0,    3'd7);
        add_event(2'd1, 1'b0, 1'b0, 4'd5,  10'h2AA,  3'd0);
        add_event(2'd1, 1'b0, 1'b0, 4'd5,  10'd0,    3'd0);
        // Full attenuation counts as silence.
        add_event(2'd2, 1'b0, 1'b0, 4'd15, 10'h155,  3'd0);
        add_event(2'd2, 1'b0, 1'b0, 4'd1,  10'h155,  3'd0);
        add_event(2'd2, 1'b0, 1'b0, 4'd15, 10'h155,  3'd0);
        // The noise voice ignores the tone period, even a zero one.
        add_event(2'd3, 1'b0, 1'b0, 4'd8,  10'd0,    3'd7);
        add_event(2'd3, 1'b0, 1'b0, 4'd8,  10'd0,    3'd0);
        add_event(2'd3, 1'b0, 1'b0, 4'd8,  10'd0,    3'd0);
        add_event(2'd3, 1'b1, 1'b1, 4'd8,  10'd0,    3'd0);
        add_event(2'd3, 1'b0, 1'b0, 4'd0,  10'd0,    3'd0);
        add_event(2'd3, 1'b0, 1'b0, 4'd0,  10'd1023, 3'd3);
        add_event(2'd2, 1'b0, 1'b0, 4'd7,  10'd1023, 3'd7);
        add_event(2'd1, 1'b1, 1'b1, 4'd15, 10'd1023, 3'd7);

        // Random events. Tones come mostly, and volumes half the time, from small pools so
        // repeats and retunes of sounding voices are common; silencing is kept a minority.
        tone_pool[0] = 10'd1023;
        tone_pool[1] = 10'h155;
        tone_pool[2] = 10'h2AA;
        tone_pool[3] = 10'd1;
        att_pool[0]  = 4'd0;
        att_pool[1]  = 4'd9;
        att_pool[2]  = 4'd14;
        for (n = 0; n < RANDOM_EVENTS; n++) begin
            v = 2'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r >= 84 && r < 88) begin
                period = '0;
            end else if ($urandom_range(0, 2) == 0) begin
                period = 10'($urandom_range(0, 1023));
            end else begin
                period = tone_pool[$urandom_range(0, 3)];
            end
            if (r < 8) begin
                att = pncw_pkg::ATT_OFF;
            end else if ($urandom_range(0, 1) == 0) begin
                att = 4'($urandom_range(0, 14));
            end else begin
                att = att_pool[$urandom_range(0, 2)];
            end
            mode = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            add_event(v, (r >= 92 && r < 96), (r >= 96), att, period, mode);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every event is taken and every predicted beat has come out,
        // then let the block run on for DRAIN_CYCLES to show any stray beat.
        do begin
            @(negedge i_clk);
        end while (pending_events.size() != 0 || i_in_valid || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
